>>> rtl/fdl_pkg.sv
// ----------------------------------------------------------------------------
// fdl_pkg
// shared types and codes of the fingerprint dedupe lookup/insert block
// ----------------------------------------------------------------------------
package fdl_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_ADDED = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2*WORD_W-1:0] high;
    logic [2*WORD_W-1:0] mid;
    logic [WORD_W-1:0]   low;
  } fp_t;

  typedef struct packed {
    fp_t               fp;
    logic [WORD_W-1:0] chunk;
  } entry_t;

endpackage

>>> rtl/fdl_if.sv
// ----------------------------------------------------------------------------
// fdl_if
// request and result channels of the fingerprint dedupe block
// ----------------------------------------------------------------------------
interface fdl_in_if;
  logic                       valid;
  logic                       ready;
  logic [fdl_pkg::WORD_W-1:0] fp_word0;
  logic [fdl_pkg::WORD_W-1:0] fp_word1;
  logic [fdl_pkg::WORD_W-1:0] fp_word2;
  logic [fdl_pkg::WORD_W-1:0] fp_word3;
  logic [fdl_pkg::WORD_W-1:0] fp_word4;

  modport source (
    output valid, fp_word0, fp_word1, fp_word2, fp_word3, fp_word4,
    input  ready
  );
  modport sink (
    input  valid, fp_word0, fp_word1, fp_word2, fp_word3, fp_word4,
    output ready
  );
endinterface

interface fdl_out_if;
  logic                       valid;
  logic                       ready;
  fdl_pkg::status_t           status;
  logic [fdl_pkg::WORD_W-1:0] chunk_id;

  modport source (output valid, status, chunk_id, input ready);
  modport sink (input valid, status, chunk_id, output ready);
endinterface

>>> rtl/fingerprint_dedupe_lookup_insert.sv
// ----------------------------------------------------------------------------
// fingerprint_dedupe_lookup_insert
// bucketed fingerprint index: lookup with insert on miss
// ----------------------------------------------------------------------------
// in_chan carries one 160-bit fingerprint request as five words; out_chan
// returns one result (status, chunk_id) per request, valid/ready on both.
// word 4 mod BUCKET_COUNT picks a bucket, computed after accept by a
// remainder unit (reciprocal multiply, multiply-subtract, one correction).
// the fill count of the bucket is then read from its memory and
// the entries are read back one per cycle from the entry memory, each
// compared the cycle after its read.
// the time from accept to result grows with the fill count of the bucket,
// set by the single read port of the entry memory; one request is in
// flight at a time and the next can be accepted once the block is back in
// idle, which it enters as the result is loaded into the output register.
// a miss with room appends the fingerprint and the next global id; a miss
// in a full bucket returns FULL with id 0.
// after reset the fill memory is cleared one bucket a cycle, all buckets in
// turn, with in_chan.ready low. a stalled receiver holds the result in the
// output register, and a finished request waits for it before writing back.
// ----------------------------------------------------------------------------
module fingerprint_dedupe_lookup_insert #(
  parameter int unsigned BUCKET_COUNT = 256,
  parameter int unsigned BUCKET_DEPTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  fdl_in_if.sink    in_chan,
  fdl_out_if.source out_chan
);

  localparam int unsigned BW    = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned FW    = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned SLOTS = BUCKET_COUNT * BUCKET_DEPTH;
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned WW    = fdl_pkg::WORD_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_FILL  = 5'b01000,
    S_SCAN  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [BW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [BW-1:0]     bucket_r, bucket_nxt;
  logic [SW-1:0]     base_r, base_nxt;
  logic [FW-1:0]     k_r, k_nxt;
  logic              pend_r, pend_nxt;
  logic [WW-1:0]     next_id_r, next_id_nxt;
  fdl_pkg::fp_t      fp_r;
  logic              out_valid_r, out_valid_nxt;
  fdl_pkg::status_t  out_status_r, out_status_nxt;
  logic [WW-1:0]     out_chunk_r, out_chunk_nxt;

  logic              in_acc;
  logic              can_emit;
  logic              hit;
  logic              mod_done;
  logic [BW-1:0]     mod_rem;

  // bucket fill memory
  logic [FW-1:0]     fill_mem [BUCKET_COUNT];
  logic              fill_we, fill_re;
  logic [BW-1:0]     fill_waddr, fill_raddr;
  logic [FW-1:0]     fill_wdata, fill_q;

  // entry memory
  fdl_pkg::entry_t   ent_mem [SLOTS];
  logic              ent_we, ent_re;
  logic [SW-1:0]     ent_waddr, ent_raddr;
  fdl_pkg::entry_t   ent_wdata, ent_q;

  fdl_mod #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (in_chan.fp_word4),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign in_chan.ready   = (state_r == S_IDLE);
  assign in_acc          = in_chan.valid && in_chan.ready;
  assign can_emit        = !out_valid_r || out_chan.ready;
  assign hit             = pend_r && (ent_q.fp == fp_r);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.chunk_id = out_chunk_r;

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    bucket_nxt     = bucket_r;
    base_nxt       = base_r;
    k_nxt          = k_r;
    pend_nxt       = pend_r;
    next_id_nxt    = next_id_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_chunk_nxt  = out_chunk_r;
    fill_we        = 1'b0;
    fill_waddr     = bucket_r;
    fill_wdata     = fill_q + 1'b1;
    fill_re        = 1'b0;
    fill_raddr     = mod_rem;
    ent_we         = 1'b0;
    ent_waddr      = base_r + SW'(fill_q);
    ent_wdata      = '{fp: fp_r, chunk: next_id_r};
    ent_re         = 1'b0;
    ent_raddr      = base_r + SW'(k_r);
    case (state_r)
      S_CLEAR: begin
        fill_we     = 1'b1;
        fill_waddr  = clr_idx_r;
        fill_wdata  = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == BW'(BUCKET_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          fill_re    = 1'b1;
          bucket_nxt = mod_rem;
          base_nxt   = SW'(32'(mod_rem) * 32'(BUCKET_DEPTH));
          state_nxt  = S_FILL;
        end
      end
      S_FILL: begin
        k_nxt     = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          if (can_emit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = fdl_pkg::ST_FOUND;
            out_chunk_nxt  = ent_q.chunk;
            pend_nxt       = 1'b0;
            state_nxt      = S_IDLE;
          end
        end else if (k_r < fill_q) begin
          ent_re   = 1'b1;
          k_nxt    = k_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (can_emit) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (fill_q < FW'(BUCKET_DEPTH)) begin
              fill_we        = 1'b1;
              ent_we         = 1'b1;
              out_status_nxt = fdl_pkg::ST_ADDED;
              out_chunk_nxt  = next_id_r;
              next_id_nxt    = next_id_r + 1'b1;
            end else begin
              out_status_nxt = fdl_pkg::ST_FULL;
              out_chunk_nxt  = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      pend_r      <= 1'b0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      pend_r      <= pend_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bucket_r     <= bucket_nxt;
    base_r       <= base_nxt;
    k_r          <= k_nxt;
    out_status_r <= out_status_nxt;
    out_chunk_r  <= out_chunk_nxt;
    if (in_acc) begin
      fp_r <= '{high: {in_chan.fp_word0, in_chan.fp_word1},
                mid:  {in_chan.fp_word2, in_chan.fp_word3},
                low:  in_chan.fp_word4};
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (fill_re) begin
      fill_q <= fill_mem[fill_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_q <= ent_mem[ent_raddr];
    end
  end

  // an entry is appended only below the bucket depth
  assert property (@(posedge clk) disable iff (!rst_n)
    ent_we |-> (fill_q < FW'(BUCKET_DEPTH)))
    else $error("append into a full bucket");

  // the id counter moves only with an added result
  assert property (@(posedge clk) disable iff (!rst_n)
    (next_id_r != $past(next_id_r)) |->
      (out_valid_r && out_status_r == fdl_pkg::ST_ADDED &&
       !$past(out_valid_r && !out_chan.ready)))
    else $error("id counter moved without an added result");

  // the scan never runs past the fill count
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (k_r <= fill_q))
    else $error("scan index beyond fill count");

  // a full result carries id zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == fdl_pkg::ST_FULL) |-> (out_chunk_r == '0))
    else $error("full result with nonzero id");

  // no request is taken while the fill memory is being cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_chan.ready)
    else $error("request accepted during clearing pass");

endmodule

>>> rtl/fdl_mod.sv
// ----------------------------------------------------------------------------
// fdl_mod
// remainder of a 32-bit word by a constant through a reciprocal multiply
// ----------------------------------------------------------------------------
module fdl_mod #(
  parameter int unsigned BUCKET_COUNT = 256,
  localparam int unsigned BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fdl_pkg::WORD_W-1:0] dividend,
  output logic                       done,
  output logic [BW-1:0]              rem
);

  localparam int unsigned   WW    = fdl_pkg::WORD_W;
  localparam int unsigned   PW    = 2 * fdl_pkg::WORD_W;
  localparam int unsigned   RW    = $clog2(BUCKET_COUNT) + 1;
  localparam logic [RW-1:0] DIV   = RW'(BUCKET_COUNT);
  localparam logic [PW-1:0] ONES  = PW'({fdl_pkg::WORD_W{1'b1}});
  // floor((2^32 - 1) / divisor): the quotient estimate is exact or one short
  localparam logic [WW-1:0] RECIP = WW'(ONES / PW'(BUCKET_COUNT));

  logic [2:0]    stg_r, stg_nxt;
  logic          done_r, done_nxt;
  logic [WW-1:0] x_r, x_nxt;
  logic [WW-1:0] q_r, q_nxt;
  logic [RW-1:0] r_r, r_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [PW-1:0] prod;

  assign prod = PW'(x_r) * PW'(RECIP);

  always_comb begin
    stg_nxt  = {stg_r[1:0], start};
    done_nxt = stg_r[2];
    x_nxt    = start ? dividend : x_r;
    q_nxt    = prod[PW-1:WW];
    // remainder estimate lies below twice the divisor
    r_nxt    = x_r[RW-1:0] - q_r[RW-1:0] * DIV;
    rem_nxt  = (r_r >= DIV) ? (r_r - DIV) : r_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r  <= '0;
      done_r <= 1'b0;
    end else begin
      stg_r  <= stg_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = BW'(rem_r);

endmodule
